/* rtl/core/fpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants for the frame playback pacer: sequencer states,
// arithmetic unit operations, configuration register indexes and queue entry.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int TAG_W  = 8;
  localparam int IVAL_W = 16;
  localparam int TIME_W = 32;
  localparam int LAT_W  = 16;
  localparam int BURST_W = 3;
  localparam int OCNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LAT_W-1:0]   MAX_LATENCY_RESET = 16'd500;
  localparam logic [BURST_W-1:0] BURST_LIMIT_RESET = 3'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT = 2'd1;

  // Input item kinds
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_EXP_SUB,
    S_EXP_CMP,
    S_EXP_LOAD,
    S_DECIDE,
    S_CU_SUB,
    S_CU_CMP,
    S_CU_SUB2,
    S_CU_SNAP,
    S_CU_LOAD,
    S_FIN
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef enum logic [1:0] {
    B_TIME,
    B_LAST,
    B_IVAL
  } b_sel_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [IVAL_W-1:0] ival;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  // Operands for the shared arithmetic unit
  typedef struct packed {
    alu_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  // Per-cycle controls from the sequencer
  typedef struct packed {
    logic   enq;
    logic   pop;
    logic   exp_inc;
    logic   shown_inc;
    logic   push;
    logic   fin;
    logic   fin_frame;
    logic   acc_load;
    logic   last_now;
    logic   last_alu;
    logic   play_set;
    logic   play_clr;
    logic   a_now;
    b_sel_t b_sel;
    alu_op_t op;
  } ctrl_t;

endpackage

/* rtl/core/fpp_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_alu
// Shared 32-bit wrapping add/subtract unit used by the pacer sequencer for
// frame ages, elapsed time and schedule advance.
// ----------------------------------------------------------------------------
module fpp_alu import fpp_pkg::*; (
  input  alu_req_t          req,
  output logic [TIME_W-1:0] y
);

  // Add or subtract, modulo 2^32
  always_comb begin
    unique case (req.op)
      ALU_SUB: y = req.a - req.b;
      ALU_ADD: y = req.a + req.b;
      default: y = req.a - req.b;
    endcase
  end

endmodule

/* rtl/core/frame_playback_pacer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_playback_pacer
// Frame queue with latency expiry and interval pacing, one item at a time.
// Enqueue: the S_ENQ state writes the queue and registers the result.
// Tick: S_EXP_SUB, S_EXP_CMP and S_EXP_LOAD repeat per expired frame, then S_DECIDE;
// a catch-up tick repeats S_CU_SUB to S_CU_LOAD per frame shown and closes in
// S_FIN, also when it stops on a frame not yet due or shows a zero-interval frame.
// Next item is taken at the edge of the final transfer; the receiver cannot stall.
// Synchronous reset empties the queue, clears playing, sets max_latency to 500 ms, burst_limit to 3.
// ----------------------------------------------------------------------------
module frame_playback_pacer import fpp_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [TAG_W-1:0]      frame_tag,
  input  logic [IVAL_W-1:0]     interval_ms,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic                  frame_valid,
  output logic [TAG_W-1:0]      shown_tag,
  output logic [OCNT_W-1:0]     expired_count,
  output logic                  accepted,
  output logic [OCNT_W-1:0]     queue_count,
  output logic                  last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [LAT_W-1:0]   max_latency;
  logic [BURST_W-1:0] burst_limit;

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [PTR_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic               full;

  logic               is_tick;
  logic [TIME_W-1:0]  now_q;
  logic [TAG_W-1:0]   tag_q;
  logic [IVAL_W-1:0]  ival_q;
  logic [TIME_W-1:0]  last_time;
  logic               playing;
  logic [TIME_W-1:0]  acc;
  logic [CNT_W-1:0]   expired;
  logic [BURST_W-1:0] shown;

  logic               pend_valid;
  logic [TAG_W-1:0]   pend_tag;
  logic [OCNT_W-1:0]  pend_exp;
  logic [OCNT_W-1:0]  pend_qc;

  alu_req_t           alu_req;
  logic [TIME_W-1:0]  alu_y;
  logic [TIME_W-1:0]  ival_x2;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign ival_x2   = {15'd0, rd_data.ival, 1'b0};

  // Tail slot: head plus fill, wrapped at the queue depth
  assign tail_sum = {1'b0, head} + (PTR_W+1)'(count);
  assign tail = (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                PTR_W'(tail_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_latency <= MAX_LATENCY_RESET;
      burst_limit <= BURST_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_LATENCY: max_latency <= cfg_data;
        CFG_BURST_LIMIT: burst_limit <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (kind == KIND_TICK) ? S_EXP_SUB : S_ENQ;
        end
      end
      S_ENQ:      state_next = S_IDLE;
      S_EXP_SUB:  state_next = (count == '0) ? S_DECIDE : S_EXP_CMP;
      S_EXP_CMP:  state_next = (acc > TIME_W'(max_latency)) ? S_EXP_LOAD : S_DECIDE;
      S_EXP_LOAD: state_next = S_EXP_SUB;
      S_DECIDE:   state_next = (count != '0 && playing) ? S_CU_SUB : S_IDLE;
      S_CU_SUB: begin
        if (count == '0 || shown >= burst_limit || rd_data.ival == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_CU_CMP;
        end
      end
      S_CU_CMP:   state_next = (acc < TIME_W'(rd_data.ival)) ? S_FIN : S_CU_SUB2;
      S_CU_SUB2:  state_next = S_CU_SNAP;
      S_CU_SNAP:  state_next = S_CU_LOAD;
      S_CU_LOAD:  state_next = S_CU_SUB;
      S_FIN:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Per-state controls
  always_comb begin
    ctrl       = '0;
    ctrl.a_now = 1'b1;
    ctrl.b_sel = B_TIME;
    ctrl.op    = ALU_SUB;
    unique case (state)
      S_IDLE: ;
      S_ENQ:  ctrl.enq = 1'b1;
      S_EXP_SUB: begin
        ctrl.acc_load = 1'b1;
      end
      S_EXP_CMP: begin
        if (acc > TIME_W'(max_latency)) begin
          ctrl.pop     = 1'b1;
          ctrl.exp_inc = 1'b1;
        end
      end
      S_EXP_LOAD: ;
      S_DECIDE: begin
        ctrl.fin = 1'b1;
        if (count == '0) begin
          ctrl.play_clr = 1'b1;
        end else if (!playing) begin
          ctrl.fin_frame = 1'b1;
          ctrl.pop       = 1'b1;
          ctrl.play_set  = 1'b1;
          ctrl.last_now  = 1'b1;
        end else begin
          ctrl.fin = 1'b0;
        end
      end
      S_CU_SUB: begin
        ctrl.b_sel = B_LAST;
        if (count != '0 && shown < burst_limit) begin
          if (rd_data.ival == '0) begin
            ctrl.last_now  = 1'b1;
            ctrl.pop       = 1'b1;
            ctrl.push      = 1'b1;
            ctrl.shown_inc = 1'b1;
          end else begin
            ctrl.acc_load = 1'b1;
          end
        end
      end
      S_CU_CMP: begin
        ctrl.a_now = 1'b0;
        ctrl.b_sel = B_IVAL;
        ctrl.op    = ALU_ADD;
        if (acc >= TIME_W'(rd_data.ival)) begin
          ctrl.last_alu = 1'b1;
        end
      end
      S_CU_SUB2: begin
        ctrl.b_sel    = B_LAST;
        ctrl.acc_load = 1'b1;
      end
      S_CU_SNAP: begin
        ctrl.last_now  = (acc > ival_x2);
        ctrl.pop       = 1'b1;
        ctrl.push      = 1'b1;
        ctrl.shown_inc = 1'b1;
      end
      S_CU_LOAD: ;
      S_FIN: begin
        ctrl.fin      = 1'b1;
        ctrl.play_clr = (count == '0);
      end
      default: ;
    endcase
  end

  // Operand select for the shared unit
  always_comb begin
    alu_req.op = ctrl.op;
    alu_req.a  = ctrl.a_now ? now_q : last_time;
    case (ctrl.b_sel)
      B_TIME:  alu_req.b = rd_data.arrival;
      B_LAST:  alu_req.b = last_time;
      B_IVAL:  alu_req.b = TIME_W'(rd_data.ival);
      default: alu_req.b = rd_data.arrival;
    endcase
  end

  fpp_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Queue memory: write at tail, registered read of head
  always_ff @(posedge clk) begin
    if (ctrl.enq && !full) begin
      mem[tail] <= '{tag: tag_q, ival: ival_q, arrival: now_q};
    end
    rd_data <= mem[head];
  end

  // Queue pointers and player state
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      playing <= 1'b0;
    end else begin
      if (ctrl.enq && !full) begin
        count <= count + 1'b1;
      end else if (ctrl.pop) begin
        count <= count - 1'b1;
        head  <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (ctrl.play_set) begin
        playing <= 1'b1;
      end else if (ctrl.play_clr) begin
        playing <= 1'b0;
      end
    end
  end

  // Schedule time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
    end else if (ctrl.last_now) begin
      last_time <= now_q;
    end else if (ctrl.last_alu) begin
      last_time <= alu_y;
    end
  end

  // Capture the item and hold per-tick working values
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      is_tick <= kind;
      now_q   <= now_ms;
      tag_q   <= frame_tag;
      ival_q  <= interval_ms;
      expired <= '0;
      shown   <= '0;
    end else begin
      if (ctrl.exp_inc) begin
        expired <= expired + 1'b1;
      end
      if (ctrl.shown_inc) begin
        shown <= shown + 1'b1;
      end
    end
    if (ctrl.acc_load) begin
      acc <= alu_y;
    end
  end

  // Pending catch-up result, held until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctrl.push) begin
      pend_valid <= 1'b1;
    end else if (ctrl.fin || (state == S_IDLE && start)) begin
      pend_valid <= 1'b0;
    end
    if (ctrl.push) begin
      pend_tag <= rd_data.tag;
      pend_exp <= (shown == '0) ? OCNT_W'(expired) : '0;
      pend_qc  <= OCNT_W'(count - 1'b1);
    end
  end

  // Result register: one transfer per strobe cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.enq || ctrl.fin || (ctrl.push && pend_valid);
    end
    if (ctrl.enq) begin
      frame_valid   <= 1'b0;
      shown_tag     <= '0;
      expired_count <= '0;
      accepted      <= !full;
      queue_count   <= full ? OCNT_W'(count) : OCNT_W'(count + 1'b1);
      last          <= 1'b1;
    end else if (ctrl.fin) begin
      accepted <= 1'b0;
      last     <= 1'b1;
      if (ctrl.fin_frame) begin
        frame_valid   <= 1'b1;
        shown_tag     <= rd_data.tag;
        expired_count <= OCNT_W'(expired);
        queue_count   <= OCNT_W'(count - 1'b1);
      end else if (pend_valid) begin
        frame_valid   <= 1'b1;
        shown_tag     <= pend_tag;
        expired_count <= pend_exp;
        queue_count   <= pend_qc;
      end else begin
        frame_valid   <= 1'b0;
        shown_tag     <= '0;
        expired_count <= OCNT_W'(expired);
        queue_count   <= OCNT_W'(count);
      end
    end else if (ctrl.push && pend_valid) begin
      frame_valid   <= 1'b1;
      shown_tag     <= pend_tag;
      expired_count <= pend_exp;
      accepted      <= 1'b0;
      queue_count   <= pend_qc;
      last          <= 1'b0;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result while still busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result after the item ended");

  a_enq_kind: assert property (@(posedge clk) disable iff (rst)
    state == S_ENQ |-> !is_tick)
    else $error("enqueue path taken by a tick");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> shown < burst_limit)
    else $error("burst limit exceeded");

endmodule
